### rtl/cll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types and constants of the cursor linked list engine: operation and
// status codes, datapath command and status groups.
// ----------------------------------------------------------------------------
package cll_pkg;

   localparam int NODES_DFLT = 16;
   localparam int KIND_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 5;
   localparam int STATUS_W   = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT   = 2'd0,
      KIND_FIND     = 2'd1,
      KIND_DELETE   = 2'd2,
      KIND_TRAVERSE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      DP_NONE      = 4'd0,
      DP_LOAD      = 4'd1,
      DP_SET_FULL  = 4'd2,
      DP_SET_MISS  = 4'd3,
      DP_SET_EMPTY = 4'd4,
      DP_TAKE      = 4'd5,
      DP_ADV       = 4'd6,
      DP_INS_POP   = 4'd7,
      DP_INS_CLR   = 4'd8,
      DP_INS_LINK  = 4'd9,
      DP_FIND_HIT  = 4'd10,
      DP_DEL_A     = 4'd11,
      DP_DEL_B     = 4'd12,
      DP_DEL_C     = 4'd13,
      DP_OUT_RES   = 4'd14,
      DP_OUT_TRV   = 4'd15
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic link_zero;
      logic link_bad;
      logic link_small;
      logic room;
      logic hit;
      logic pos_match;
      logic pos_ok;
      logic fin;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/cll_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll channels
// Valid/ready channels of the engine: request items in, response items out.
// ----------------------------------------------------------------------------
interface cll_req_if;
   import cll_pkg::*;

   logic                       valid;
   logic                       ready;
   kind_type                   kind;
   logic signed [VALUE_W-1:0]  value;
   logic        [POS_W-1:0]    position;

   modport source (output valid, kind, value, position, input ready);
   modport sink   (input valid, kind, value, position, output ready);
endinterface

interface cll_rsp_if;
   import cll_pkg::*;

   logic                       valid;
   logic                       ready;
   status_type                 status;
   logic        [POS_W-1:0]    node_index;
   logic signed [VALUE_W-1:0]  element;
   logic                       last;

   modport source (output valid, status, node_index, element, last, input ready);
   modport sink   (input valid, status, node_index, element, last, output ready);
endinterface

### rtl/cll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_ctrl
// Sequencer of the engine: walks each operation through its steps and
// issues one datapath command per cycle, with none while a result waits on a busy output.
// ----------------------------------------------------------------------------
module cll_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  cll_pkg::kind_type      req_kind,
   output logic                   req_ready,
   input  cll_pkg::dp_status_type dp_status,
   output cll_pkg::dp_cmd_type    dp_cmd
);
   import cll_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE      = 14'h0001,
      S_INS_CHK   = 14'h0002,
      S_INS_POP   = 14'h0004,
      S_INS_CLR   = 14'h0008,
      S_INS_WALK  = 14'h0010,
      S_FIND_NEXT = 14'h0020,
      S_FIND_CMP  = 14'h0040,
      S_DEL_WALK  = 14'h0080,
      S_DEL_A     = 14'h0100,
      S_DEL_B     = 14'h0200,
      S_DEL_C     = 14'h0400,
      S_TRV_CHK   = 14'h0800,
      S_TRV_EMIT  = 14'h1000,
      S_EMIT      = 14'h2000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      more;

   assign req_ready = (state_ff == S_IDLE);
   assign more      = dp_status.room && !dp_status.link_zero && !dp_status.link_bad;

   always_comb begin
      state_in   = state_ff;
      dp_cmd.op  = DP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = DP_LOAD;
               unique case (req_kind)
                  KIND_INSERT:   state_in = S_INS_CHK;
                  KIND_FIND:     state_in = S_FIND_NEXT;
                  KIND_DELETE:   state_in = S_DEL_WALK;
                  KIND_TRAVERSE: state_in = S_TRV_CHK;
               endcase
            end
         end
         S_INS_CHK: begin
            if (dp_status.link_small || dp_status.link_bad) begin
               dp_cmd.op = DP_SET_FULL;
               state_in  = S_EMIT;
            end else begin
               dp_cmd.op = DP_TAKE;
               state_in  = S_INS_POP;
            end
         end
         S_INS_POP: begin
            dp_cmd.op = DP_INS_POP;
            state_in  = S_INS_CLR;
         end
         S_INS_CLR: begin
            dp_cmd.op = DP_INS_CLR;
            state_in  = S_INS_WALK;
         end
         S_INS_WALK: begin
            if (dp_status.room && !dp_status.link_zero) begin
               dp_cmd.op = DP_ADV;
            end else begin
               dp_cmd.op = DP_INS_LINK;
               state_in  = S_EMIT;
            end
         end
         S_FIND_NEXT: begin
            if (more) begin
               dp_cmd.op = DP_TAKE;
               state_in  = S_FIND_CMP;
            end else begin
               dp_cmd.op = DP_SET_MISS;
               state_in  = S_EMIT;
            end
         end
         S_FIND_CMP: begin
            priority if (dp_status.hit) begin
               dp_cmd.op = DP_FIND_HIT;
               state_in  = S_EMIT;
            end else if (more) begin
               dp_cmd.op = DP_TAKE;
            end else begin
               dp_cmd.op = DP_SET_MISS;
               state_in  = S_EMIT;
            end
         end
         S_DEL_WALK: begin
            priority if (!dp_status.pos_ok || !more) begin
               dp_cmd.op = DP_SET_MISS;
               state_in  = S_EMIT;
            end else if (dp_status.pos_match) begin
               dp_cmd.op = DP_TAKE;
               state_in  = S_DEL_A;
            end else begin
               dp_cmd.op = DP_ADV;
            end
         end
         S_DEL_A: begin
            dp_cmd.op = DP_DEL_A;
            state_in  = S_DEL_B;
         end
         S_DEL_B: begin
            dp_cmd.op = DP_DEL_B;
            state_in  = S_DEL_C;
         end
         S_DEL_C: begin
            dp_cmd.op = DP_DEL_C;
            state_in  = S_EMIT;
         end
         S_TRV_CHK: begin
            if (dp_status.link_zero || dp_status.link_bad) begin
               dp_cmd.op = DP_SET_EMPTY;
               state_in  = S_EMIT;
            end else begin
               dp_cmd.op = DP_TAKE;
               state_in  = S_TRV_EMIT;
            end
         end
         S_TRV_EMIT: begin
            if (dp_status.out_free) begin
               dp_cmd.op = DP_OUT_TRV;
               if (dp_status.fin) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (dp_status.out_free) begin
               dp_cmd.op = DP_OUT_RES;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_del_after_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEL_A |-> $past(state_ff) == S_DEL_WALK)
      else $error("delete unlink entered without a matching walk");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !dp_status.out_free) |=> state_ff == S_EMIT)
      else $error("pending result dropped while output busy");

   a_pop_after_take: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_POP |-> $past(dp_cmd.op) == DP_TAKE)
      else $error("free list popped without taking a node");

endmodule

### rtl/cll_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_dpath
// Node store, walk registers, result staging and output register of the
// engine. Link store reads as the initial free chain until an entry is
// written.
// ----------------------------------------------------------------------------
module cll_dpath #(
   parameter int NODES = cll_pkg::NODES_DFLT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cll_pkg::dp_cmd_type                 cmd,
   input  cll_pkg::kind_type                   req_kind,
   input  logic signed [cll_pkg::VALUE_W-1:0]  req_value,
   input  logic        [cll_pkg::POS_W-1:0]    req_position,
   output cll_pkg::dp_status_type              dp_status,
   cll_rsp_if.source                           rsp_if
);
   import cll_pkg::*;

   localparam int STORE = NODES + 2;
   localparam int IDX_W = $clog2(STORE);
   localparam int CNT_W = $clog2(STORE + 1);

   logic [IDX_W-1:0]   lnk_mem [STORE];
   logic [VALUE_W-1:0] val_mem [STORE];
   logic [STORE-1:0]   lnk_vld_ff;

   logic [IDX_W-1:0]   lnk_rd_data_ff;
   logic [IDX_W-1:0]   lnk_rd_addr_ff;
   logic               lnk_rd_vld_ff;
   logic [VALUE_W-1:0] val_rd_data_ff;

   logic               lnk_re, lnk_we, val_re, val_we;
   logic [IDX_W-1:0]   lnk_ra, lnk_wa, lnk_wd, val_ra;
   logic [IDX_W-1:0]   link_q;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   p_ff, p_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;

   status_type         res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_node_ff, res_node_in;
   logic [VALUE_W-1:0] res_elem_ff, res_elem_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_node_ff, rsp_node_in;
   logic [VALUE_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_load;

   function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] a);
      if (a == '0) begin
         return IDX_W'(2);
      end else if (a == IDX_W'(1) || int'(a) == STORE - 1) begin
         return '0;
      end else begin
         return a + IDX_W'(1);
      end
   endfunction

   always_comb begin
      if (int'(lnk_rd_addr_ff) >= STORE) begin
         link_q = '0;
      end else if (lnk_rd_vld_ff) begin
         link_q = lnk_rd_data_ff;
      end else begin
         link_q = reset_link(lnk_rd_addr_ff);
      end
   end

   assign dp_status.link_zero  = (link_q == '0);
   assign dp_status.link_bad   = (int'(link_q) >= STORE);
   assign dp_status.link_small = (link_q < IDX_W'(2));
   assign dp_status.room       = (int'(steps_ff) < STORE);
   assign dp_status.hit        = (val_rd_data_ff == value_ff);
   assign dp_status.pos_match  = (int'(link_q) == int'(pos_ff));
   assign dp_status.pos_ok     = (pos_ff >= POS_W'(2)) && (int'(pos_ff) < STORE);
   assign dp_status.fin        = (link_q == '0) || (int'(link_q) >= STORE) ||
                                 (int'(steps_ff) >= NODES);
   assign dp_status.out_free   = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      lnk_re        = 1'b0;
      lnk_ra        = link_q;
      val_re        = 1'b0;
      val_ra        = link_q;
      lnk_we        = 1'b0;
      lnk_wa        = p_ff;
      lnk_wd        = '0;
      val_we        = 1'b0;
      value_in      = value_ff;
      pos_in        = pos_ff;
      p_in          = p_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_elem_in   = res_elem_ff;
      out_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (cmd.op)
         DP_NONE: begin
         end
         DP_LOAD: begin
            value_in = req_value;
            pos_in   = req_position;
            lnk_re   = 1'b1;
            lnk_ra   = (req_kind == KIND_INSERT) ? '0 : IDX_W'(1);
            prev_in  = IDX_W'(1);
            steps_in = '0;
         end
         DP_SET_FULL: begin
            res_status_in = ST_FULL;
            res_node_in   = '0;
            res_elem_in   = '0;
         end
         DP_SET_MISS: begin
            res_status_in = ST_MISS;
            res_node_in   = '0;
            res_elem_in   = '0;
         end
         DP_SET_EMPTY: begin
            res_status_in = ST_EMPTY;
            res_node_in   = '0;
            res_elem_in   = '0;
         end
         DP_TAKE: begin
            p_in     = link_q;
            lnk_re   = 1'b1;
            val_re   = 1'b1;
            steps_in = steps_ff + CNT_W'(1);
         end
         DP_ADV: begin
            prev_in  = link_q;
            lnk_re   = 1'b1;
            steps_in = steps_ff + CNT_W'(1);
         end
         DP_INS_POP: begin
            lnk_we = 1'b1;
            lnk_wa = '0;
            lnk_wd = link_q;
            val_we = 1'b1;
         end
         DP_INS_CLR: begin
            lnk_we   = 1'b1;
            lnk_wa   = p_ff;
            lnk_wd   = '0;
            lnk_re   = 1'b1;
            lnk_ra   = IDX_W'(1);
            prev_in  = IDX_W'(1);
            steps_in = '0;
         end
         DP_INS_LINK: begin
            lnk_we        = 1'b1;
            lnk_wa        = prev_ff;
            lnk_wd        = p_ff;
            res_status_in = ST_OK;
            res_node_in   = p_ff;
            res_elem_in   = value_ff;
         end
         DP_FIND_HIT: begin
            res_status_in = ST_OK;
            res_node_in   = p_ff;
            res_elem_in   = value_ff;
         end
         DP_DEL_A: begin
            lnk_we        = 1'b1;
            lnk_wa        = prev_ff;
            lnk_wd        = link_q;
            lnk_re        = 1'b1;
            lnk_ra        = '0;
            res_status_in = ST_OK;
            res_node_in   = p_ff;
            res_elem_in   = val_rd_data_ff;
         end
         DP_DEL_B: begin
            lnk_we = 1'b1;
            lnk_wa = p_ff;
            lnk_wd = link_q;
         end
         DP_DEL_C: begin
            lnk_we = 1'b1;
            lnk_wa = '0;
            lnk_wd = p_ff;
         end
         DP_OUT_RES: begin
            out_load      = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_node_in   = POS_W'(res_node_ff);
            rsp_elem_in   = res_elem_ff;
            rsp_last_in   = 1'b1;
         end
         DP_OUT_TRV: begin
            out_load      = 1'b1;
            rsp_status_in = ST_OK;
            rsp_node_in   = POS_W'(p_ff);
            rsp_elem_in   = val_rd_data_ff;
            rsp_last_in   = dp_status.fin;
            // advance to the next node
            p_in          = link_q;
            lnk_re        = 1'b1;
            val_re        = 1'b1;
            steps_in      = steps_ff + CNT_W'(1);
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lnk_we && int'(lnk_wa) < STORE) begin
         lnk_mem[lnk_wa] <= lnk_wd;
      end
      if (lnk_re) begin
         lnk_rd_addr_ff <= lnk_ra;
         if (int'(lnk_ra) < STORE) begin
            lnk_rd_data_ff <= lnk_mem[lnk_ra];
            lnk_rd_vld_ff  <= lnk_vld_ff[lnk_ra];
         end else begin
            lnk_rd_data_ff <= '0;
            lnk_rd_vld_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (val_we && int'(p_ff) < STORE) begin
         val_mem[p_ff] <= value_ff;
      end
      if (val_re && int'(val_ra) < STORE) begin
         val_rd_data_ff <= val_mem[val_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lnk_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (lnk_we && int'(lnk_wa) < STORE) begin
            lnk_vld_ff[lnk_wa] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      p_ff          <= p_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_elem_ff   <= res_elem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.node_index = rsp_node_ff;
   assign rsp_if.element    = $signed(rsp_elem_ff);
   assign rsp_if.last       = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_OUT_RES || cmd.op == DP_OUT_TRV) |-> dp_status.out_free)
      else $error("output register overwritten while an item waits");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (lnk_we && lnk_re) |-> lnk_wa != lnk_ra)
      else $error("link store read and written at one address");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_TAKE || cmd.op == DP_ADV || cmd.op == DP_OUT_TRV) |->
      int'(steps_ff) < STORE)
      else $error("walk ran past the size of the store");

endmodule

### rtl/cursor_linked_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// Insert: free-list check and pop, node clear, tail walk one link read a cycle, then link.
// Find and delete walk the list node by node; one item at a time.
// Traverse: one item per cycle from the link/value ports while the response side is ready.
// Reset: synchronous; link store reads as the initial free chain at once, values undefined.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core #(
   parameter int NODES = cll_pkg::NODES_DFLT
) (
   input  logic       clock,
   input  logic       reset,
   cll_req_if.sink    req_if,
   cll_rsp_if.source  rsp_if
);
   import cll_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   cll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   cll_dpath #(
      .NODES (NODES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .req_kind     (req_if.kind),
      .req_value    (req_if.value),
      .req_position (req_if.position),
      .dp_status    (dp_status),
      .rsp_if       (rsp_if)
   );

endmodule

### dv/cursor_linked_list_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core_tb
// Drives insert, find, delete and traverse items into the list engine and
// checks every response item, field by field, against a preset answer or a
// behavioural copy of the node store and its free list kept in the bench.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core_tb;
   import cll_pkg::*;

   localparam int NODES       = NODES_DFLT;
   localparam int STORE       = NODES + 2;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int N_DIR       = 29;

   typedef struct packed {
      status_type                status;
      logic [POS_W-1:0]          node_index;
      logic signed [VALUE_W-1:0] element;
      logic                      last;
   } answer_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      logic                      typed;
      answer_type                answer;
   } stim_row_type;

   logic clock;
   logic reset;

   cll_req_if req_if ();
   cll_rsp_if rsp_if ();

   cursor_linked_list_engine_core #(.NODES(NODES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [POS_W-1:0]          link_mem [STORE];
   logic signed [VALUE_W-1:0] elem_mem [STORE];
   answer_type                op_answers [$];
   answer_type                due_answers [$];

   int unsigned req_idle_pct = 28;
   int unsigned rsp_idle_pct = 87;
   bit          hold_off_req = 1'b0;
   bit          growing      = 1'b1;
   int          errors       = 0;
   int          quiet_cycles = 0;

   stim_row_type dir_rows [N_DIR] = '{
      '{KIND_TRAVERSE, 32'sd0,           5'd0,  1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 1'b1}},
      '{KIND_FIND,     32'sd0,           5'd0,  1'b1, '{ST_MISS,  5'd0, 32'sd0, 1'b1}},
      '{KIND_DELETE,   32'sd0,           5'd2,  1'b1, '{ST_MISS,  5'd0, 32'sd0, 1'b1}},
      '{KIND_DELETE,   32'sd0,           5'd1,  1'b1, '{ST_MISS,  5'd0, 32'sd0, 1'b1}},
      '{KIND_INSERT,   32'sh8000_0000,   5'd0,  1'b1,
        '{ST_OK, 5'd2, 32'sh8000_0000, 1'b1}},
      '{KIND_INSERT,   32'sh7fff_ffff,   5'd0,  1'b1,
        '{ST_OK, 5'd3, 32'sh7fff_ffff, 1'b1}},
      '{KIND_FIND,     32'sh7fff_ffff,   5'd0,  1'b1,
        '{ST_OK, 5'd3, 32'sh7fff_ffff, 1'b1}},
      '{KIND_DELETE,   32'sd0,           5'd0,  1'b1, '{ST_MISS,  5'd0, 32'sd0, 1'b1}},
      '{KIND_DELETE,   32'sd0,           5'd31, 1'b1, '{ST_MISS,  5'd0, 32'sd0, 1'b1}},
      '{KIND_DELETE,   32'sd0,           5'd2,  1'b1,
        '{ST_OK, 5'd2, 32'sh8000_0000, 1'b1}},
      '{KIND_INSERT,   -32'sd1,          5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd0,           5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd1,           5'd0,  1'b0, '0},
      '{KIND_INSERT,   -32'sd1,          5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sh5555_5555,   5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'shaaaa_aaaa,   5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd100,         5'd0,  1'b0, '0},
      '{KIND_INSERT,   -32'sd100,        5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd0,           5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd7,           5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd8,           5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd9,           5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd10,          5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd11,          5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd12,          5'd0,  1'b0, '0},
      '{KIND_INSERT,   32'sd5,           5'd0,  1'b1, '{ST_FULL,  5'd0, 32'sd0, 1'b1}},
      '{KIND_TRAVERSE, 32'sd0,           5'd0,  1'b0, '0},
      '{KIND_FIND,     -32'sd1,          5'd0,  1'b0, '0},
      '{KIND_DELETE,   32'sd0,           5'd17, 1'b0, '0}
   };

   function automatic void note_answer(status_type st, logic [POS_W-1:0] node,
                                       logic signed [VALUE_W-1:0] elem, logic fin);
      op_answers.push_back(answer_type'{st, node, elem, fin});
   endfunction

   function automatic void apply_list_op(kind_type kind, logic signed [VALUE_W-1:0] value,
                                         logic [POS_W-1:0] position);
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] prev;
      logic [POS_W-1:0] nx;
      int               n;
      case (kind)
         KIND_INSERT: begin
            p = link_mem[0];
            if (p < 2) begin
               note_answer(ST_FULL, '0, '0, 1'b1);
               return;
            end
            link_mem[0] = link_mem[p];
            elem_mem[p] = value;
            link_mem[p] = '0;
            prev = 5'd1;
            for (n = 0; n < STORE && link_mem[prev] != 0; n++)
               prev = link_mem[prev];
            link_mem[prev] = p;
            note_answer(ST_OK, p, value, 1'b1);
         end
         KIND_FIND: begin
            p = link_mem[1];
            for (n = 0; n < STORE && p != 0; n++) begin
               if (elem_mem[p] == value) begin
                  note_answer(ST_OK, p, value, 1'b1);
                  return;
               end
               p = link_mem[p];
            end
            note_answer(ST_MISS, '0, '0, 1'b1);
         end
         KIND_DELETE: begin
            if (position >= 2 && position < STORE) begin
               prev = 5'd1;
               for (n = 0; n < STORE; n++) begin
                  p = link_mem[prev];
                  if (p == 0)
                     break;
                  if (p == position) begin
                     link_mem[prev] = link_mem[p];
                     link_mem[p]    = link_mem[0];
                     link_mem[0]    = p;
                     note_answer(ST_OK, p, elem_mem[p], 1'b1);
                     return;
                  end
                  prev = p;
               end
            end
            note_answer(ST_MISS, '0, '0, 1'b1);
         end
         default: begin
            p = link_mem[1];
            if (p == 0) begin
               note_answer(ST_EMPTY, '0, '0, 1'b1);
               return;
            end
            for (n = 0; n < NODES && p != 0; n++) begin
               nx = link_mem[p];
               note_answer(ST_OK, p, elem_mem[p], (nx == 0) || (n + 1 >= NODES));
               p = nx;
            end
         end
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_list_node();
      logic [POS_W-1:0] members [$];
      logic [POS_W-1:0] p;
      p = link_mem[1];
      while (p != 0 && members.size() < NODES) begin
         members.push_back(p);
         p = link_mem[p];
      end
      if (members.size() == 0)
         return '0;
      return members[$urandom_range(members.size() - 1)];
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_element();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return ($urandom_range(1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type     row;
      int unsigned      pick;
      logic [POS_W-1:0] node;
      row          = '0;
      row.value    = $urandom;
      row.position = POS_W'($urandom_range(31));
      pick         = $urandom_range(99);
      if (pick < (growing ? 50 : 20)) begin
         row.kind  = KIND_INSERT;
         row.value = random_element();
      end else if (pick < (growing ? 65 : 40)) begin
         row.kind = KIND_FIND;
         node     = pick_list_node();
         if (node != 0 && $urandom_range(9) < 6)
            row.value = elem_mem[node];
         else
            row.value = random_element();
      end else if (pick < 88) begin
         row.kind = KIND_DELETE;
         if ($urandom_range(9) < 7)
            row.position = pick_list_node();
      end else begin
         row.kind = KIND_TRAVERSE;
      end
      return row;
   endfunction

   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.kind     <= row.kind;
      req_if.value    <= row.value;
      req_if.position <= row.position;
      do @(posedge clock); while (!req_if.ready);
      op_answers.delete();
      apply_list_op(row.kind, row.value, row.position);
      if (row.typed)
         due_answers.push_back(row.answer);
      else
         foreach (op_answers[i]) due_answers.push_back(op_answers[i]);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(24) == 0)
            growing = !growing;
         send_item(random_row());
      end
   endtask

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : rsp_pacing
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_answers.size() == 0) begin
            $error("response item with none due: node_index %0d element %0d",
                   rsp_if.node_index, rsp_if.element);
            errors++;
         end else begin
            want = due_answers.pop_front();
            check_field("status", want.status, rsp_if.status);
            check_field("node_index", want.node_index, rsp_if.node_index);
            check_field("element", want.element, rsp_if.element);
            check_field("last", want.last, rsp_if.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      link_mem[0] = 5'd2;
      link_mem[1] = 5'd0;
      for (int i = 2; i < STORE; i++)
         link_mem[i] = (i + 1 < STORE) ? POS_W'(i + 1) : '0;
      for (int i = 0; i < STORE; i++)
         elem_mem[i] = '0;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_INSERT;
      req_if.value    <= '0;
      req_if.position <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i]);
      run_random(145);

      req_idle_pct = 87;
      rsp_idle_pct = 28;
      run_random(145);

      // hold the response side while items keep arriving
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_off_req = 1'b1;
      run_random(140);
      req_if.valid <= 1'b0;

      while (due_answers.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
